// ----- rtl/core/igrp_update_parser_macros.svh -----
// Assertion macros used by the checker file.
`ifndef IGRP_UPDATE_PARSER_MACROS_SVH
`define IGRP_UPDATE_PARSER_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define IGRP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define IGRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ----- rtl/core/igrp_pkg.sv -----
package igrp_pkg;
	localparam int unsigned HdrLen = 12;
	localparam int unsigned EntryLen = 14;
	localparam logic [23:0] UnreachDelay = 24'hFFFFFF;
	localparam logic [23:0] BwNumerator = 24'd10000000;
	localparam logic [15:0] DefaultMaxRoutes = 16'd50;
	localparam logic [3:0] OpcodeMask = 4'h0F;
	localparam int unsigned QuotWidth = 24;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_ROUTE = 2'd1,
		KIND_END = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_COMPLETE = 3'd0,
		ST_SHORT = 3'd1,
		ST_BAD_OP = 3'd2,
		ST_CAPPED = 3'd3,
		ST_MISSING = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIVIDE,
		S_EMIT_MAIN,
		S_EMIT_END
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take_byte;
		logic div_start;
		logic load_main;
		logic load_end;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic main_rec;
		logic need_div;
		logic is_last;
		logic div_done;
	} sts_t;
endpackage

// ----- rtl/core/igrp_div.sv -----
// Restoring divider, one quotient bit per cycle.
module igrp_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [23:0] divisor,
	output logic done,
	output logic [23:0] quotient
);
	import igrp_pkg::*;

	logic [23:0] rem_q;
	logic [23:0] quot_q;
	logic [23:0] dvs_q;
	logic [4:0] cnt_q;
	logic busy_q;
	logic [24:0] trial;

	// Shift in the next numerator bit and try a subtract.
	always_comb begin
		trial = {rem_q, quot_q[23]} - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= 5'(QuotWidth);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quot_q <= BwNumerator;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[24]) begin
				rem_q <= trial[23:0];
				quot_q <= {quot_q[22:0], 1'b1};
			end else begin
				rem_q <= {rem_q[22:0], quot_q[23]};
				quot_q <= {quot_q[22:0], 1'b0};
			end
		end
	end

	assign done = busy_q && (cnt_q == 5'd1);
	assign quotient = quot_q;
endmodule

// ----- rtl/core/igrp_dp.sv -----
// Parser datapath: byte storage, counters and output record register.
module igrp_dp (
	input logic clk,
	input logic arst_n,
	input igrp_pkg::cmd_t cmd,
	output igrp_pkg::sts_t sts,
	input logic cfg_we,
	input logic [15:0] cfg_data,
	input logic [7:0] payload_byte,
	input logic [31:0] source_address,
	input logic last_byte,
	output logic [1:0] record_kind,
	output logic [1:0] route_class,
	output logic [31:0] address,
	output logic [27:0] delay_us,
	output logic unreachable,
	output logic [23:0] bandwidth,
	output logic [15:0] mtu,
	output logic [7:0] reliability,
	output logic [7:0] load,
	output logic [7:0] hops,
	output logic [2:0] status,
	output logic last_result
);
	import igrp_pkg::*;

	logic [15:0] max_routes_q;
	logic [3:0] hpos_q;
	logic [3:0] epos_q;
	logic op_bad_q;
	logic [7:0] hdr_q [11];
	logic [7:0] ent_q [13];
	logic [15:0] int_rem_q;
	logic [15:0] sys_rem_q;
	logic [15:0] ext_rem_q;
	logic [17:0] decl_q;
	logic [17:0] dec_q;
	// Captured word and pending route.
	logic [7:0] byte_q;
	logic [31:0] src_q;
	logic last_q;
	logic route_q;
	logic [1:0] cls_q;
	logic [31:0] addr_q;
	logic [23:0] delay_q;
	logic [23:0] bw_q;
	// Decoded status of the arriving word.
	logic in_hdr;
	logic hdr_done;
	logic route_done;
	logic [17:0] limit;
	logic [3:0] op_nib;
	logic div_done;
	logic [23:0] quot;

	// The divider starts in the same cycle the last entry byte is taken, so it
	// reads the raw bandwidth straight from the entry store.
	igrp_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.div_start),
		.divisor({ent_q[6], ent_q[7], ent_q[8]}),
		.done(div_done),
		.quotient(quot)
	);

	// Classify the arriving word against the current state.
	always_comb begin
		in_hdr = hpos_q < 4'(HdrLen);
		hdr_done = in_hdr && (hpos_q == 4'(HdrLen - 1)) && !op_bad_q;
		limit = (decl_q < {2'b0, max_routes_q}) ? decl_q : {2'b0, max_routes_q};
		route_done = !in_hdr && !op_bad_q && (epos_q == 4'(EntryLen - 1)) && (dec_q < limit);
		op_nib = payload_byte[3:0] & OpcodeMask;
	end

	assign sts.main_rec = hdr_done || route_done;
	assign sts.need_div = route_done && ({ent_q[6], ent_q[7], ent_q[8]} != 24'd0);
	assign sts.is_last = last_byte;
	assign sts.div_done = div_done;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_routes_q <= DefaultMaxRoutes;
		end else if (cfg_we) begin
			max_routes_q <= cfg_data;
		end
	end

	// Packet state updated when a word is taken, cleared after the end record.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hpos_q <= '0;
			epos_q <= '0;
			op_bad_q <= 1'b0;
			int_rem_q <= '0;
			sys_rem_q <= '0;
			ext_rem_q <= '0;
			decl_q <= '0;
			dec_q <= '0;
		end else if (cmd.load_end) begin
			hpos_q <= '0;
			epos_q <= '0;
			op_bad_q <= 1'b0;
			int_rem_q <= '0;
			sys_rem_q <= '0;
			ext_rem_q <= '0;
			decl_q <= '0;
			dec_q <= '0;
		end else if (cmd.take_byte) begin
			if (in_hdr) begin
				if (hpos_q == 4'd0) begin
					op_bad_q <= (op_nib != 4'd1) && (op_nib != 4'd2);
				end
				if (hpos_q == 4'(HdrLen - 1)) begin
					int_rem_q <= {hdr_q[4], hdr_q[5]};
					sys_rem_q <= {hdr_q[6], hdr_q[7]};
					ext_rem_q <= {hdr_q[8], hdr_q[9]};
					decl_q <= 18'({hdr_q[4], hdr_q[5]}) + 18'({hdr_q[6], hdr_q[7]})
						+ 18'({hdr_q[8], hdr_q[9]});
					dec_q <= '0;
					epos_q <= '0;
				end
				hpos_q <= hpos_q + 4'd1;
			end else if (!op_bad_q) begin
				if (epos_q < 4'(EntryLen - 1)) begin
					epos_q <= epos_q + 4'd1;
				end else begin
					epos_q <= '0;
					if (dec_q < limit) begin
						dec_q <= dec_q + 18'd1;
						if (int_rem_q != 16'd0) begin
							int_rem_q <= int_rem_q - 16'd1;
						end else if (sys_rem_q != 16'd0) begin
							sys_rem_q <= sys_rem_q - 16'd1;
						end else if (ext_rem_q != 16'd0) begin
							ext_rem_q <= ext_rem_q - 16'd1;
						end
					end
				end
			end
		end
	end

	// Byte stores and the captured route fields.
	always_ff @(posedge clk) begin
		if (cmd.take_byte) begin
			byte_q <= payload_byte;
			src_q <= source_address;
			last_q <= last_byte;
			route_q <= route_done;
			if (in_hdr && (hpos_q < 4'(HdrLen - 1))) begin
				hdr_q[hpos_q] <= payload_byte;
			end
			if (!in_hdr && !op_bad_q && (epos_q < 4'(EntryLen - 1))) begin
				ent_q[epos_q] <= payload_byte;
			end
			if (int_rem_q != 16'd0) begin
				cls_q <= 2'd0;
				addr_q <= {source_address[31:24], ent_q[0], ent_q[1], ent_q[2]};
			end else begin
				cls_q <= (sys_rem_q != 16'd0) ? 2'd1 : 2'd2;
				addr_q <= {ent_q[0], ent_q[1], ent_q[2], 8'd0};
			end
			delay_q <= {ent_q[3], ent_q[4], ent_q[5]};
			bw_q <= {ent_q[6], ent_q[7], ent_q[8]};
		end
	end

	// Output record register.
	always_ff @(posedge clk) begin
		if (cmd.load_main) begin
			route_class <= '0;
			address <= '0;
			delay_us <= '0;
			unreachable <= 1'b0;
			bandwidth <= '0;
			reliability <= '0;
			load <= '0;
			hops <= '0;
			status <= '0;
			last_result <= !last_q;
			if (route_q) begin
				record_kind <= KIND_ROUTE;
				route_class <= cls_q;
				address <= addr_q;
				unreachable <= delay_q == UnreachDelay;
				delay_us <= (delay_q == UnreachDelay) ? 28'd0
					: 28'({4'd0, delay_q} * 28'd10);
				bandwidth <= (bw_q != 24'd0) ? quot : 24'd0;
				mtu <= {ent_q[9], ent_q[10]};
				reliability <= ent_q[11];
				load <= ent_q[12];
				hops <= byte_q;
			end else begin
				record_kind <= KIND_HEADER;
				address <= {hdr_q[0][3:0], hdr_q[0][7:4], hdr_q[1], hdr_q[2], hdr_q[3]};
				mtu <= {hdr_q[10], byte_q};
			end
		end else if (cmd.load_end) begin
			record_kind <= KIND_END;
			route_class <= '0;
			address <= '0;
			delay_us <= '0;
			unreachable <= 1'b0;
			bandwidth <= '0;
			mtu <= '0;
			reliability <= '0;
			load <= '0;
			hops <= '0;
			last_result <= 1'b1;
			if (hpos_q < 4'(HdrLen)) begin
				status <= ST_SHORT;
			end else if (op_bad_q) begin
				status <= ST_BAD_OP;
			end else if (decl_q > {2'b0, max_routes_q}) begin
				status <= ST_CAPPED;
			end else if (dec_q < decl_q) begin
				status <= ST_MISSING;
			end else begin
				status <= ST_COMPLETE;
			end
		end
	end
endmodule

// ----- rtl/core/igrp_ctrl.sv -----
// Parser controller: sequences word intake, division and record output.
module igrp_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input igrp_pkg::sts_t sts,
	output igrp_pkg::cmd_t cmd
);
	import igrp_pkg::*;

	state_t state_q;
	state_t state_d;
	logic ov_q;
	logic end_pend_q;
	logic out_free;
	logic take;

	assign out_free = !ov_q || out_ready;
	assign take = (state_q == S_IDLE) && !end_pend_q && in_valid;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (take && sts.need_div) begin
					state_d = S_DIVIDE;
				end else if (take && sts.main_rec) begin
					state_d = S_EMIT_MAIN;
				end else if (take && sts.is_last) begin
					state_d = S_EMIT_END;
				end
			end
			S_DIVIDE: begin
				if (sts.div_done) begin
					state_d = S_EMIT_MAIN;
				end
			end
			S_EMIT_MAIN: begin
				if (out_free) begin
					state_d = end_pend_q ? S_EMIT_END : S_IDLE;
				end
			end
			S_EMIT_END: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		in_ready = (state_q == S_IDLE) && !end_pend_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.take_byte = take;
				cmd.div_start = take && sts.need_div;
			end
			S_EMIT_MAIN: cmd.load_main = out_free;
			S_EMIT_END: cmd.load_end = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q <= 1'b0;
			end_pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_main || cmd.load_end) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
			if (take) begin
				end_pend_q <= sts.is_last && sts.main_rec;
			end else if (cmd.load_main) begin
				end_pend_q <= end_pend_q;
			end else if (cmd.load_end) begin
				end_pend_q <= 1'b0;
			end
		end
	end

	assign out_valid = ov_q;
endmodule

// ----- rtl/core/igrp_update_parser.sv -----
// IGRP update parser. Payload bytes are taken one word at a time with the
// source address; records leave through a one-deep output register. A byte
// that yields no record is only stored; a header or route record also loads
// the output register, and a last byte also yields an end record, after any
// header or route record. A route with nonzero bandwidth first runs the
// restoring divider, one quotient bit per cycle, for its 14-byte route entry.
module igrp_update_parser (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [15:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] payload_byte,
	input logic [31:0] source_address,
	input logic last_byte,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] record_kind,
	output logic [1:0] route_class,
	output logic [31:0] address,
	output logic [27:0] delay_us,
	output logic unreachable,
	output logic [23:0] bandwidth,
	output logic [15:0] mtu,
	output logic [7:0] reliability,
	output logic [7:0] load,
	output logic [7:0] hops,
	output logic [2:0] status,
	output logic last_result
);
	import igrp_pkg::*;

	cmd_t cmd;
	sts_t sts;

	igrp_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts(sts),
		.cmd(cmd)
	);

	igrp_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.payload_byte(payload_byte),
		.source_address(source_address),
		.last_byte(last_byte),
		.record_kind(record_kind),
		.route_class(route_class),
		.address(address),
		.delay_us(delay_us),
		.unreachable(unreachable),
		.bandwidth(bandwidth),
		.mtu(mtu),
		.reliability(reliability),
		.load(load),
		.hops(hops),
		.status(status),
		.last_result(last_result)
	);
endmodule

// ----- rtl/core/igrp_checker.sv -----
`include "igrp_update_parser_macros.svh"
// Port-level checks on the parser.
module igrp_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] record_kind,
	input logic [2:0] status,
	input logic last_result
);
	import igrp_pkg::*;

	// A held result word keeps its kind.
	`IGRP_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, $stable(record_kind))
	// End records always close the byte's results.
	`IGRP_ASSERT_IMP(a_end_last, clk, arst_n, out_valid && record_kind == KIND_END, last_result)
	// Status is zero outside end records.
	`IGRP_ASSERT_IMP(a_stat, clk, arst_n, out_valid && record_kind != KIND_END, status == ST_COMPLETE)
	// An offered word stays offered until it is taken.
	`IGRP_ASSERT_NEXT(a_in_hold, clk, arst_n, in_valid && !in_ready, in_valid)
endmodule

bind igrp_update_parser igrp_checker u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.record_kind(record_kind),
	.status(status),
	.last_result(last_result)
);
